@@ design/fpt_pkg.sv @@
// Shared constants and control types for the FIR filter with peak tracking.
package fpt_pkg;

  localparam int MAX_TAPS      = 128;
  localparam int SAMPLE_BITS   = 16;
  localparam int OUT_BITS      = 40;
  localparam int TAP_CNT_BITS  = 8;
  localparam int COEF_IDX_BITS = 7;

  localparam int CNT_W  = $clog2(MAX_TAPS);
  localparam int TAPS_W = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;

  localparam int ACC_RAW_W = PROD_W + CNT_W + 1;
  localparam int ACC_W     = (ACC_RAW_W > OUT_BITS) ? ACC_RAW_W : OUT_BITS;

  localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RESET = TAP_CNT_BITS'(100);

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic acc_clear;
    logic mul_act;
    logic peak_clear;
    logic sat_en;
    logic commit;
  } mac_ctl_t;

endpackage

@@ design/fpt_cell.sv @@
// One tap cell: holds a delay-line sample and its coefficient on a rotating ring.
module fpt_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpt_pkg::cell_ctl_t                   ctl,
  input  logic                                 load,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0] load_value,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0] shift_in,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0] rot_s_in,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0] rot_c_in,
  output logic signed [fpt_pkg::SAMPLE_BITS-1:0] s_out,
  output logic signed [fpt_pkg::SAMPLE_BITS-1:0] c_out
);

  logic signed [fpt_pkg::SAMPLE_BITS-1:0] s;
  logic signed [fpt_pkg::SAMPLE_BITS-1:0] c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s <= '0;
      c <= '0;
    end else if (ctl.rotate) begin
      s <= rot_s_in;
      c <= rot_c_in;
    end else begin
      if (ctl.shift) begin
        s <= shift_in;
      end
      if (load) begin
        c <= load_value;
      end
    end
  end

  assign s_out = s;
  assign c_out = c;

endmodule

@@ design/fpt_mac.sv @@
// Multiply-accumulate at the head of the ring, saturation and running peak.
module fpt_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fpt_pkg::mac_ctl_t                      ctl,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0] s_tap,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0] c_tap,
  output logic signed [fpt_pkg::OUT_BITS-1:0]    res,
  output logic        [fpt_pkg::OUT_BITS-1:0]    peak_new
);

  localparam logic [fpt_pkg::OUT_BITS-1:0] OUT_MIN = {1'b1, {(fpt_pkg::OUT_BITS-1){1'b0}}};
  localparam logic [fpt_pkg::OUT_BITS-1:0] OUT_MAX = {1'b0, {(fpt_pkg::OUT_BITS-1){1'b1}}};

  logic signed [fpt_pkg::PROD_W-1:0]   prod;
  logic                                prod_act;
  logic signed [fpt_pkg::ACC_W-1:0]    acc;
  logic        [fpt_pkg::OUT_BITS-1:0] peak;
  logic [fpt_pkg::ACC_W-fpt_pkg::OUT_BITS:0] acc_hi;
  logic                                fits;
  logic        [fpt_pkg::OUT_BITS-1:0] sat;
  logic        [fpt_pkg::OUT_BITS-1:0] mag;

  assign acc_hi = acc[fpt_pkg::ACC_W-1:fpt_pkg::OUT_BITS-1];
  assign fits   = (&acc_hi) || ~(|acc_hi);
  assign sat    = fits ? acc[fpt_pkg::OUT_BITS-1:0] :
                  (acc[fpt_pkg::ACC_W-1] ? OUT_MIN : OUT_MAX);

  assign mag      = res[fpt_pkg::OUT_BITS-1] ? (fpt_pkg::OUT_BITS'(0) - $unsigned(res))
                                             : $unsigned(res);
  assign peak_new = (mag > peak) ? mag : peak;

  always_ff @(posedge clk) begin
    prod <= s_tap * c_tap;
    if (ctl.acc_clear) begin
      acc <= '0;
    end else if (prod_act) begin
      acc <= acc + fpt_pkg::ACC_W'(prod);
    end
    if (ctl.sat_en) begin
      res <= $signed(sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_act <= 1'b0;
      peak     <= '0;
    end else begin
      prod_act <= ctl.mul_act;
      if (ctl.peak_clear) begin
        peak <= '0;
      end else if (ctl.commit) begin
        peak <= peak_new;
      end
    end
  end

endmodule

@@ design/fir_filter_with_peak_tracking.sv @@
// Top level: FIR filter over a rotating ring of tap cells, with running peak.
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_we               cfg_wdata (tap_count)
//  in       in         in_valid / in_ready  req_type, sample, start_of_signal,
//                                           coef_index, coef_value
//  out      out        out_valid / out_ready filtered, peak_magnitude
//
// A coefficient load is written into its cell while idle. A sample request
// rotates the ring of cells once past the single multiplier, then drains,
// saturates and commits. Reset (rst, synchronous) clears the delay
// line, the coefficient table and the peak, and sets tap_count to 100.
// A result waiting on out_ready holds the block in its commit step only;
// coefficient loads and the next request can be taken while a result waits.
module fir_filter_with_peak_tracking (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic        [fpt_pkg::TAP_CNT_BITS-1:0]    cfg_wdata,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       req_type,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic                                       start_of_signal,
  input  logic        [fpt_pkg::COEF_IDX_BITS-1:0]   coef_index,
  input  logic signed [fpt_pkg::SAMPLE_BITS-1:0]     coef_value,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [fpt_pkg::OUT_BITS-1:0]        filtered,
  output logic        [fpt_pkg::OUT_BITS-1:0]        peak_magnitude
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_SAT,
    S_DONE
  } state_t;

  state_t                             state;
  logic [fpt_pkg::CNT_W-1:0]          cnt;
  logic [fpt_pkg::TAP_CNT_BITS-1:0]   tap_count;
  logic [fpt_pkg::TAPS_W-1:0]         taps_eff;
  logic                               accept;
  logic                               smp_acc;
  logic                               coef_acc;
  logic                               out_free;
  fpt_pkg::cell_ctl_t                 cell_ctl;
  fpt_pkg::mac_ctl_t                  mac_ctl;
  logic signed [fpt_pkg::SAMPLE_BITS-1:0] s_q [fpt_pkg::MAX_TAPS];
  logic signed [fpt_pkg::SAMPLE_BITS-1:0] c_q [fpt_pkg::MAX_TAPS];
  logic signed [fpt_pkg::OUT_BITS-1:0]    res;
  logic        [fpt_pkg::OUT_BITS-1:0]    peak_new;
  logic        [fpt_pkg::OUT_BITS-1:0]    out_mag;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign smp_acc  = accept && !req_type;
  assign coef_acc = accept && req_type;
  assign out_free = !out_valid || out_ready;

  assign taps_eff = (tap_count > fpt_pkg::MAX_TAPS) ? fpt_pkg::TAPS_W'(fpt_pkg::MAX_TAPS)
                                                    : fpt_pkg::TAPS_W'(tap_count);

  always_comb begin
    cell_ctl.shift  = smp_acc;
    cell_ctl.rotate = (state == S_RUN);

    mac_ctl.acc_clear  = smp_acc;
    mac_ctl.mul_act    = (state == S_RUN) && (fpt_pkg::TAPS_W'(cnt) < taps_eff);
    mac_ctl.peak_clear = smp_acc && start_of_signal;
    mac_ctl.sat_en     = (state == S_SAT);
    mac_ctl.commit     = (state == S_DONE) && out_free;
  end

  for (genvar k = 0; k < fpt_pkg::MAX_TAPS; k++) begin : g_tap
    logic signed [fpt_pkg::SAMPLE_BITS-1:0] shift_in;
    logic                                   load;

    if (k == 0) begin : g_head
      assign shift_in = sample;
    end else begin : g_body
      assign shift_in = start_of_signal ? '0 : s_q[k-1];
    end

    assign load = coef_acc && (32'(coef_index) == k);

    fpt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl),
      .load       (load),
      .load_value (coef_value),
      .shift_in   (shift_in),
      .rot_s_in   (s_q[(k + 1) % fpt_pkg::MAX_TAPS]),
      .rot_c_in   (c_q[(k + 1) % fpt_pkg::MAX_TAPS]),
      .s_out      (s_q[k]),
      .c_out      (c_q[k])
    );
  end

  fpt_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .s_tap    (s_q[0]),
    .c_tap    (c_q[0]),
    .res      (res),
    .peak_new (peak_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fpt_pkg::TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= mac_ctl.commit || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (smp_acc) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == fpt_pkg::CNT_W'(fpt_pkg::MAX_TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_SAT;
        end
        S_SAT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            filtered       <= res;
            peak_magnitude <= peak_new;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_mag = filtered[fpt_pkg::OUT_BITS-1] ?
                   (fpt_pkg::OUT_BITS'(0) - $unsigned(filtered)) : $unsigned(filtered);

  a_peak_covers_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_magnitude >= out_mag))
    else $error("peak below magnitude of result");

  a_sample_starts_run: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> (state == S_RUN) && (cnt == '0))
    else $error("sample request did not start the ring pass");

  a_drain_after_full_pass: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> ($past(state) == S_RUN) &&
                           ($past(cnt) == fpt_pkg::CNT_W'(fpt_pkg::MAX_TAPS - 1)))
    else $error("ring left before a full rotation");

  a_commit_frees_slot: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.commit |=> out_valid && (state == S_IDLE))
    else $error("commit did not present a result");

endmodule
